/* rtl/core/ult_pkg.sv */
// ----------------------------------------------------------------------------
// ult_pkg: shared types and constants of the literal transcoder
// Encoding kinds, register indexes, queue entry layout and scalar checks.
// ----------------------------------------------------------------------------
package ult_pkg;

	// encoding kinds; codes 5..7 behave as plain
	localparam logic [2:0] KIND_PLAIN = 3'd0;
	localparam logic [2:0] KIND_UTF8  = 3'd1;
	localparam logic [2:0] KIND_UTF16 = 3'd2;
	localparam logic [2:0] KIND_UTF32 = 3'd3;
	localparam logic [2:0] KIND_WIDE  = 3'd4;

	// configuration register indexes
	localparam logic [1:0] REG_SOURCE_KIND    = 2'd0;
	localparam logic [1:0] REG_TARGET_KIND    = 2'd1;
	localparam logic [1:0] REG_WIDE_UNIT_BITS = 2'd2;

	localparam int          CFG_DATA_W   = 6;
	localparam logic [5:0]  WIDE_RESET   = 6'd32;

	localparam logic [31:0] REPL         = 32'h0000_FFFD;
	localparam logic [31:0] MAX_SCALAR   = 32'h0010_FFFF;
	localparam logic [31:0] SURR_LO      = 32'h0000_D800;
	localparam logic [31:0] SURR_HI      = 32'h0000_DFFF;
	localparam logic [15:0] HIGH_SURR_LO = 16'hD800;
	localparam logic [15:0] HIGH_SURR_HI = 16'hDBFF;
	localparam logic [15:0] LOW_SURR_LO  = 16'hDC00;
	localparam logic [15:0] LOW_SURR_HI  = 16'hDFFF;
	localparam logic [20:0] SUPP_BASE    = 21'h01_0000;

	typedef enum logic [1:0] {
		WIDE_8,
		WIDE_16,
		WIDE_32
	} wide_sel_t;

	typedef struct packed {
		logic [2:0] src_kind;
		logic [2:0] tgt_kind;
		wide_sel_t  wide_sel;
	} cfg_t;

	// one decoded item: up to two scalar values, then an optional terminator
	typedef struct packed {
		logic [1:0]  n_cp;
		logic [31:0] cp0;
		logic [31:0] cp1;
		logic        term;
	} entry_t;

	function automatic logic bad_scalar(logic [31:0] cp);
		return (cp > MAX_SCALAR) || (cp >= SURR_LO && cp <= SURR_HI);
	endfunction

endpackage

/* rtl/core/ult_channels.sv */
// ----------------------------------------------------------------------------
// ult_channels: stream interfaces of the literal transcoder
// Source code unit channel in, target code unit channel out.
// ----------------------------------------------------------------------------
interface ult_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] in_unit;

	modport source (output valid, output in_unit, input ready);
	modport sink (input valid, input in_unit, output ready);
endinterface

interface ult_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] out_unit;
	logic        last_of_run;
	logic        end_of_literal;

	modport source (output valid, output out_unit, output last_of_run,
		output end_of_literal, input ready);
	modport sink (input valid, input out_unit, input last_of_run,
		input end_of_literal, output ready);
endinterface

/* rtl/core/ult_fifo.sv */
// ----------------------------------------------------------------------------
// ult_fifo: decoded item queue
// Small register queue between decoder and encoder; push and pop per cycle.
// ----------------------------------------------------------------------------
module ult_fifo #(
	parameter int DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  ult_pkg::entry_t wdata,
	output logic            wready,
	input  logic            pop,
	output ult_pkg::entry_t rdata,
	output logic            rvalid
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	ult_pkg::entry_t mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign wready  = (count_q != CW'(DEPTH));
	assign rvalid  = (count_q != '0);
	assign do_push = push && wready;
	assign do_pop  = pop && rvalid;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/core/ult_front.sv */
// ----------------------------------------------------------------------------
// ult_front: source decoder
// Accepts one source word per cycle while q_ready, decodes to scalars, queues.
// ----------------------------------------------------------------------------
module ult_front (
	input  logic            clk,
	input  logic            arst_n,
	input  ult_pkg::cfg_t   cfg,
	input  logic            dec_clear,
	ult_in_if.sink          in_ch,
	output logic            push,
	output ult_pkg::entry_t entry,
	input  logic            q_ready
);

	typedef enum logic [1:0] {
		MODE_BYTE,
		MODE_UTF8,
		MODE_UTF16,
		MODE_UTF32
	} mode_t;

	logic [20:0] partial_q;
	logic [2:0]  seq_len_q;
	logic [2:0]  seq_seen_q;
	logic [9:0]  pend_high_q;
	logic        high_valid_q;

	logic [20:0] partial_n;
	logic [2:0]  seq_len_n;
	logic [2:0]  seq_seen_n;
	logic [9:0]  pend_high_n;
	logic        high_valid_n;

	mode_t       mode;
	logic [31:0] unit;
	logic [7:0]  b;
	logic [15:0] w;
	logic [20:0] acc;
	logic [2:0]  seen_inc;
	logic        pre;
	logic        main_v;
	logic [31:0] main_cp;
	logic        term;
	logic        head;
	logic        accept;

	assign in_ch.ready = q_ready;
	assign accept      = in_ch.valid && q_ready;
	assign b           = unit[7:0];
	assign w           = unit[15:0];
	assign acc         = {partial_q[14:0], b[5:0]};
	assign seen_inc    = seq_seen_q + 3'd1;

	always_comb begin
		case (cfg.src_kind)
			ult_pkg::KIND_UTF8:  mode = MODE_UTF8;
			ult_pkg::KIND_UTF16: mode = MODE_UTF16;
			ult_pkg::KIND_UTF32: mode = MODE_UTF32;
			ult_pkg::KIND_WIDE: begin
				case (cfg.wide_sel)
					ult_pkg::WIDE_8:  mode = MODE_BYTE;
					ult_pkg::WIDE_16: mode = MODE_UTF16;
					default:          mode = MODE_UTF32;
				endcase
			end
			default: mode = MODE_BYTE;
		endcase
		case (mode)
			MODE_UTF32: unit = in_ch.in_unit;
			MODE_UTF16: unit = {16'd0, in_ch.in_unit[15:0]};
			default:    unit = {24'd0, in_ch.in_unit[7:0]};
		endcase
	end

	always_comb begin
		pre          = 1'b0;
		main_v       = 1'b0;
		main_cp      = unit;
		term         = 1'b0;
		head         = 1'b0;
		partial_n    = partial_q;
		seq_len_n    = seq_len_q;
		seq_seen_n   = seq_seen_q;
		pend_high_n  = pend_high_q;
		high_valid_n = high_valid_q;

		if (unit == '0) begin
			// terminator: flush any open sequence, then clear
			term         = 1'b1;
			pre          = (seq_len_q != '0) || high_valid_q;
			partial_n    = '0;
			seq_len_n    = '0;
			seq_seen_n   = '0;
			pend_high_n  = '0;
			high_valid_n = 1'b0;
		end else begin
			case (mode)
				MODE_UTF8: begin
					head = 1'b1;
					if (seq_len_q != '0) begin
						if (b[7:6] == 2'b10) begin
							head = 1'b0;
							if (seen_inc >= seq_len_q) begin
								main_v  = 1'b1;
								main_cp = {11'd0, acc};
								if ((seq_len_q == 3'd2 && acc < 21'h80) ||
									(seq_len_q == 3'd3 && acc < 21'h800) ||
									(seq_len_q == 3'd4 && acc < 21'h1_0000) ||
									ult_pkg::bad_scalar({11'd0, acc})) begin
									main_cp = ult_pkg::REPL;
								end
								partial_n  = '0;
								seq_len_n  = '0;
								seq_seen_n = '0;
							end else begin
								partial_n  = acc;
								seq_seen_n = seen_inc;
							end
						end else begin
							// broken tail: replace, then take the byte as a head
							pre        = 1'b1;
							partial_n  = '0;
							seq_len_n  = '0;
							seq_seen_n = '0;
						end
					end
					if (head) begin
						if (b[7] == 1'b0) begin
							main_v = 1'b1;
						end else if (b[7:5] == 3'b110) begin
							partial_n  = {16'd0, b[4:0]};
							seq_len_n  = 3'd2;
							seq_seen_n = 3'd1;
						end else if (b[7:4] == 4'b1110) begin
							partial_n  = {17'd0, b[3:0]};
							seq_len_n  = 3'd3;
							seq_seen_n = 3'd1;
						end else if (b[7:3] == 5'b11110) begin
							partial_n  = {18'd0, b[2:0]};
							seq_len_n  = 3'd4;
							seq_seen_n = 3'd1;
						end else begin
							main_v  = 1'b1;
							main_cp = ult_pkg::REPL;
						end
					end
				end
				MODE_UTF16: begin
					head = 1'b1;
					if (high_valid_q) begin
						pend_high_n  = '0;
						high_valid_n = 1'b0;
						if (w >= ult_pkg::LOW_SURR_LO && w <= ult_pkg::LOW_SURR_HI) begin
							head    = 1'b0;
							main_v  = 1'b1;
							main_cp = {11'd0, ult_pkg::SUPP_BASE + {1'b0, pend_high_q, w[9:0]}};
						end else begin
							pre = 1'b1;
						end
					end
					if (head) begin
						if (w >= ult_pkg::HIGH_SURR_LO && w <= ult_pkg::HIGH_SURR_HI) begin
							pend_high_n  = w[9:0];
							high_valid_n = 1'b1;
						end else if (w >= ult_pkg::LOW_SURR_LO && w <= ult_pkg::LOW_SURR_HI) begin
							main_v  = 1'b1;
							main_cp = ult_pkg::REPL;
						end else begin
							main_v = 1'b1;
						end
					end
				end
				default: begin
					main_v = 1'b1;
				end
			endcase
		end
	end

	assign push       = accept && (pre || main_v || term);
	assign entry.n_cp = {1'b0, pre} + {1'b0, main_v};
	assign entry.cp0  = pre ? ult_pkg::REPL : main_cp;
	assign entry.cp1  = main_cp;
	assign entry.term = term;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q    <= '0;
			seq_len_q    <= '0;
			seq_seen_q   <= '0;
			pend_high_q  <= '0;
			high_valid_q <= 1'b0;
		end else if (dec_clear) begin
			partial_q    <= '0;
			seq_len_q    <= '0;
			seq_seen_q   <= '0;
			pend_high_q  <= '0;
			high_valid_q <= 1'b0;
		end else if (accept) begin
			partial_q    <= partial_n;
			seq_len_q    <= seq_len_n;
			seq_seen_q   <= seq_seen_n;
			pend_high_q  <= pend_high_n;
			high_valid_q <= high_valid_n;
		end
	end

endmodule

/* rtl/core/ult_back.sv */
// ----------------------------------------------------------------------------
// ult_back: target encoder
// Pops and encodes decoded items; sends one target word per cycle while ready.
// ----------------------------------------------------------------------------
module ult_back (
	input  logic            clk,
	input  logic            arst_n,
	input  ult_pkg::cfg_t   cfg,
	input  ult_pkg::entry_t entry,
	input  logic            q_valid,
	output logic            pop,
	ult_out_if.source       out_ch
);

	typedef struct packed {
		logic [3:0][31:0] u;
		logic [2:0]       k;
	} enc_t;

	function automatic enc_t enc16(logic [20:0] s);
		enc_t        r;
		logic [19:0] o;
		r   = '0;
		o   = 20'(s - ult_pkg::SUPP_BASE);
		r.k = 3'd1;
		if (s[20:16] == '0) begin
			r.u[0] = {11'd0, s};
		end else begin
			r.u[0] = {16'd0, ult_pkg::HIGH_SURR_LO[15:10], o[19:10]};
			r.u[1] = {16'd0, ult_pkg::LOW_SURR_LO[15:10], o[9:0]};
			r.k    = 3'd2;
		end
		return r;
	endfunction

	function automatic enc_t encode(logic [31:0] cp, ult_pkg::cfg_t c);
		enc_t        r;
		logic [31:0] v;
		logic [20:0] s;
		r   = '0;
		r.k = 3'd1;
		v   = ult_pkg::bad_scalar(cp) ? ult_pkg::REPL : cp;
		s   = v[20:0];
		case (c.tgt_kind)
			ult_pkg::KIND_UTF8: begin
				if (s < 21'h80) begin
					r.u[0] = {11'd0, s};
				end else if (s < 21'h800) begin
					r.u[0] = {24'd0, 3'b110, s[10:6]};
					r.u[1] = {24'd0, 2'b10, s[5:0]};
					r.k    = 3'd2;
				end else if (s < 21'h1_0000) begin
					r.u[0] = {24'd0, 4'b1110, s[15:12]};
					r.u[1] = {24'd0, 2'b10, s[11:6]};
					r.u[2] = {24'd0, 2'b10, s[5:0]};
					r.k    = 3'd3;
				end else begin
					r.u[0] = {24'd0, 5'b11110, s[20:18]};
					r.u[1] = {24'd0, 2'b10, s[17:12]};
					r.u[2] = {24'd0, 2'b10, s[11:6]};
					r.u[3] = {24'd0, 2'b10, s[5:0]};
					r.k    = 3'd4;
				end
			end
			ult_pkg::KIND_UTF16: r = enc16(s);
			ult_pkg::KIND_UTF32: r.u[0] = v;
			ult_pkg::KIND_WIDE: begin
				case (c.wide_sel)
					ult_pkg::WIDE_8:  r.u[0] = (cp > 32'hFF) ? 32'hFD : cp;
					ult_pkg::WIDE_16: r = enc16(s);
					default:          r.u[0] = v;
				endcase
			end
			default: r.u[0] = {24'd0, cp[7:0]};
		endcase
		return r;
	endfunction

	enc_t             e0;
	enc_t             e1;
	logic [2:0]       k0;
	logic [2:0]       k1;
	logic [1:0]       j;
	logic [3:0][31:0] units_n;

	logic [3:0][31:0] units_q;
	logic [2:0]       cnt_q;
	logic [1:0]       idx_q;
	logic             term_q;
	logic             valid_q;
	logic             last;
	logic             taken;

	always_comb begin
		e0 = encode(entry.cp0, cfg);
		e1 = encode(entry.cp1, cfg);
		k0 = (entry.n_cp != '0) ? e0.k : 3'd0;
		// the second value is dropped when it would overflow four words
		if (entry.term) begin
			k1 = 3'd1;
		end else if (entry.n_cp == 2'd2 && (k0 + e1.k) <= 3'd4) begin
			k1 = e1.k;
		end else begin
			k1 = 3'd0;
		end
		for (int i = 0; i < 4; i++) begin
			j = 2'(i) - k0[1:0];
			if (3'(i) < k0) begin
				units_n[i] = e0.u[i];
			end else if (entry.term) begin
				units_n[i] = '0;
			end else begin
				units_n[i] = e1.u[j];
			end
		end
	end

	assign last  = ({1'b0, idx_q} == (cnt_q - 3'd1));
	assign taken = valid_q && out_ch.ready;
	assign pop   = q_valid && (!valid_q || (taken && last));

	assign out_ch.valid          = valid_q;
	assign out_ch.out_unit       = units_q[idx_q];
	assign out_ch.last_of_run    = last;
	assign out_ch.end_of_literal = term_q && last;

	always_ff @(posedge clk) begin
		if (pop) begin
			units_q <= units_n;
			cnt_q   <= k0 + k1;
			term_q  <= entry.term;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (pop) begin
			valid_q <= 1'b1;
			idx_q   <= '0;
		end else if (taken && last) begin
			valid_q <= 1'b0;
		end else if (taken) begin
			idx_q <= idx_q + 2'd1;
		end
	end

endmodule

/* rtl/core/unicode_literal_transcoder.sv */
// ----------------------------------------------------------------------------
// unicode_literal_transcoder: streaming string literal transcoder
// Decodes source code units to scalar values and re-encodes them to the
// configured target encoding, one source word per cycle while the queue has room.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one source code unit per word (in_unit, low bits used per
//   source width). A word whose masked unit is zero ends the literal.
//   out_ch carries one target code unit per word; last_of_run marks the last
//   word caused by one input word, end_of_literal marks the zero terminator.
//   Configuration is written through cfg_we/cfg_index/cfg_wdata while idle;
//   a write to source_kind or wide_unit_bits drops any open sequence.
// Flow:
//   The decoder takes one word per cycle until the queue is full; an accepted
//   word is registered in the queue, then in the output stage. The encoder
//   sends one word per cycle while out_ch.ready is high; an input word that
//   expands to k units holds the output for k words, and the QUEUE_DEPTH
//   entry queue absorbs the expansion; in_ch.ready drops only when it is full.
// Reset:
//   arst_n clears the queue, the output stage and the decoder state, and sets
//   source_kind = plain, target_kind = plain, wide_unit_bits = 32.
// Stall:
//   While out_ch.ready is low the current output word holds; decoded items
//   pile up in the queue until it fills, then in_ch.ready goes low.
// ----------------------------------------------------------------------------
module unicode_literal_transcoder #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [1:0]                     cfg_index,
	input  logic [ult_pkg::CFG_DATA_W-1:0] cfg_wdata,
	ult_in_if.sink                         in_ch,
	ult_out_if.source                      out_ch
);

	// configuration registers
	logic [2:0]      source_kind_q;
	logic [2:0]      target_kind_q;
	logic [5:0]      wide_bits_q;
	ult_pkg::cfg_t   cfg;
	logic            dec_clear;

	// queue between decoder and encoder
	logic            q_push;
	logic            q_wready;
	logic            q_pop;
	logic            q_rvalid;
	ult_pkg::entry_t q_wdata;
	ult_pkg::entry_t q_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_kind_q <= ult_pkg::KIND_PLAIN;
			target_kind_q <= ult_pkg::KIND_PLAIN;
			wide_bits_q   <= ult_pkg::WIDE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				ult_pkg::REG_SOURCE_KIND:    source_kind_q <= cfg_wdata[2:0];
				ult_pkg::REG_TARGET_KIND:    target_kind_q <= cfg_wdata[2:0];
				ult_pkg::REG_WIDE_UNIT_BITS: wide_bits_q   <= cfg_wdata[5:0];
				default: ;
			endcase
		end
	end

	// drop any open sequence when the source format changes
	assign dec_clear = cfg_we && (cfg_index == ult_pkg::REG_SOURCE_KIND ||
		cfg_index == ult_pkg::REG_WIDE_UNIT_BITS);

	always_comb begin
		cfg.src_kind = source_kind_q;
		cfg.tgt_kind = target_kind_q;
		if (wide_bits_q == 6'd8) begin
			cfg.wide_sel = ult_pkg::WIDE_8;
		end else if (wide_bits_q == 6'd16) begin
			cfg.wide_sel = ult_pkg::WIDE_16;
		end else begin
			cfg.wide_sel = ult_pkg::WIDE_32;
		end
	end

	ult_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.dec_clear (dec_clear),
		.in_ch     (in_ch),
		.push      (q_push),
		.entry     (q_wdata),
		.q_ready   (q_wready)
	);

	ult_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.wready (q_wready),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.rvalid (q_rvalid)
	);

	ult_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.entry   (q_rdata),
		.q_valid (q_rvalid),
		.pop     (q_pop),
		.out_ch  (out_ch)
	);

	// decoder never pushes into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> q_wready)
		else $error("decoded item pushed into full queue");

	// encoder never pops an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_rvalid)
		else $error("encoder popped empty queue");

	// terminator word is zero and closes its run
	a_term_word: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.end_of_literal) |->
		(out_ch.last_of_run && out_ch.out_unit == '0))
		else $error("terminator word malformed");

	// an accepted terminator always produces a queue entry
	a_term_pushed: assert property (@(posedge clk) disable iff (!arst_n)
		(q_wdata.term && in_ch.valid && in_ch.ready) |-> q_push)
		else $error("terminator not queued");

endmodule

/* bench/tb_unicode_literal_transcoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_unicode_literal_transcoder: self-checking bench of the literal transcoder
// Streams source code units through the block under many encoding settings.
// A scoreboard decodes and re-encodes every accepted word on its own and
// matches each output word, in order, against what it worked out.
// ----------------------------------------------------------------------------
module tb_unicode_literal_transcoder;

	// source kinds outside the defined set; the block treats them as plain
	localparam logic [2:0] KIND_UNUSED_LO = 3'd5;
	localparam logic [2:0] KIND_UNUSED_HI = 3'd7;
	// register index with no register behind it
	localparam logic [1:0] REG_SPARE = 2'd3;

	localparam int PHASES         = 16;
	localparam int WORDS_PER_PHASE = 18;
	// margin for a word still in flight through the queue and output stage
	localparam int SETTLE_CYCLES  = 8;
	localparam int WATCHDOG_LIMIT = 2000;

	localparam logic [2:0] SRC_PLAN [PHASES] = '{
		ult_pkg::KIND_PLAIN, ult_pkg::KIND_UTF8, ult_pkg::KIND_UTF16,
		ult_pkg::KIND_UTF32, ult_pkg::KIND_WIDE, KIND_UNUSED_LO,
		ult_pkg::KIND_UTF8, KIND_UNUSED_HI, ult_pkg::KIND_WIDE,
		ult_pkg::KIND_UTF8, ult_pkg::KIND_WIDE, ult_pkg::KIND_UTF16,
		ult_pkg::KIND_WIDE, ult_pkg::KIND_UTF8, ult_pkg::KIND_UTF32,
		ult_pkg::KIND_UTF16};
	localparam logic [2:0] TGT_PLAN [PHASES] = '{
		ult_pkg::KIND_UTF8, ult_pkg::KIND_UTF16, ult_pkg::KIND_UTF32,
		ult_pkg::KIND_WIDE, ult_pkg::KIND_PLAIN, KIND_UNUSED_HI,
		ult_pkg::KIND_UTF8, ult_pkg::KIND_UTF16, ult_pkg::KIND_UTF8,
		ult_pkg::KIND_WIDE, ult_pkg::KIND_WIDE, ult_pkg::KIND_UTF8,
		ult_pkg::KIND_UTF16, ult_pkg::KIND_WIDE, KIND_UNUSED_LO,
		ult_pkg::KIND_UTF32};
	localparam logic [5:0] WIDE_PLAN [PHASES] = '{
		6'd8, 6'd16, 6'd32, 6'd0, 6'd8, 6'd63, 6'd16, 6'd8,
		6'd16, 6'd8, 6'd32, 6'd16, 6'd63, 6'd16, 6'd8, 6'd0};

	typedef enum logic [1:0] {
		DEC_BYTES,
		DEC_UTF8,
		DEC_UTF16,
		DEC_UTF32
	} decode_mode_t;

	typedef struct {
		logic [31:0] unit;
		logic        last;
		logic        eol;
	} out_word_t;

	// ------------------------------------------------------------------------
	// Scoreboard: own copy of the registers and the decoder state, plus the
	// queue of output words still owed by the block.
	// ------------------------------------------------------------------------
	class transcode_scoreboard;
		logic [2:0]  src_kind;
		logic [2:0]  tgt_kind;
		logic [5:0]  wide_bits;
		logic [20:0] partial;
		logic [2:0]  seq_len;
		logic [2:0]  seq_seen;
		logic [9:0]  held_high;
		logic        high_held;
		logic [31:0] step_units [4];
		logic        step_eol [4];
		int          step_n;
		out_word_t   expected_words [$];
		int          fails;

		function new();
			src_kind  = ult_pkg::KIND_PLAIN;
			tgt_kind  = ult_pkg::KIND_PLAIN;
			wide_bits = ult_pkg::WIDE_RESET;
			fails     = 0;
			clear_decoder();
		endfunction

		function void clear_decoder();
			partial   = '0;
			seq_len   = '0;
			seq_seen  = '0;
			held_high = '0;
			high_held = 1'b0;
		endfunction

		function ult_pkg::wide_sel_t wide_unit();
			if (wide_bits == 6'd8)
				return ult_pkg::WIDE_8;
			if (wide_bits == 6'd16)
				return ult_pkg::WIDE_16;
			return ult_pkg::WIDE_32;
		endfunction

		function decode_mode_t source_mode();
			case (src_kind)
				ult_pkg::KIND_UTF8:  return DEC_UTF8;
				ult_pkg::KIND_UTF16: return DEC_UTF16;
				ult_pkg::KIND_UTF32: return DEC_UTF32;
				ult_pkg::KIND_WIDE: begin
					case (wide_unit())
						ult_pkg::WIDE_8:  return DEC_BYTES;
						ult_pkg::WIDE_16: return DEC_UTF16;
						default:          return DEC_UTF32;
					endcase
				end
				default: return DEC_BYTES;
			endcase
		endfunction

		function logic invalid_scalar(logic [31:0] cp);
			return cp > ult_pkg::MAX_SCALAR ||
				(cp >= ult_pkg::SURR_LO && cp <= ult_pkg::SURR_HI);
		endfunction

		function int as_utf16(logic [31:0] cp, output logic [31:0] u [4]);
			logic [31:0] v;
			v = invalid_scalar(cp) ? ult_pkg::REPL : cp;
			if (v <= 32'hFFFF) begin
				u[0] = v;
				return 1;
			end
			v    = v - 32'h1_0000;
			u[0] = {16'h0, ult_pkg::HIGH_SURR_LO} + (v >> 10);
			u[1] = {16'h0, ult_pkg::LOW_SURR_LO} + (v & 32'h3FF);
			return 2;
		endfunction

		function int as_utf8(logic [31:0] cp, output logic [31:0] u [4]);
			logic [31:0] v;
			v = invalid_scalar(cp) ? ult_pkg::REPL : cp;
			if (v <= 32'h7F) begin
				u[0] = v;
				return 1;
			end
			if (v <= 32'h7FF) begin
				u[0] = 32'hC0 | (v >> 6);
				u[1] = 32'h80 | (v & 32'h3F);
				return 2;
			end
			if (v <= 32'hFFFF) begin
				u[0] = 32'hE0 | (v >> 12);
				u[1] = 32'h80 | ((v >> 6) & 32'h3F);
				u[2] = 32'h80 | (v & 32'h3F);
				return 3;
			end
			u[0] = 32'hF0 | (v >> 18);
			u[1] = 32'h80 | ((v >> 12) & 32'h3F);
			u[2] = 32'h80 | ((v >> 6) & 32'h3F);
			u[3] = 32'h80 | (v & 32'h3F);
			return 4;
		endfunction

		// encode one scalar into the target; drop it when it does not fit
		function void push_scalar(logic [31:0] cp);
			logic [31:0] u [4];
			int k;
			k = 1;
			case (tgt_kind)
				ult_pkg::KIND_UTF8:  k = as_utf8(cp, u);
				ult_pkg::KIND_UTF16: k = as_utf16(cp, u);
				ult_pkg::KIND_UTF32: u[0] = invalid_scalar(cp) ? ult_pkg::REPL : cp;
				ult_pkg::KIND_WIDE: begin
					case (wide_unit())
						ult_pkg::WIDE_8:  u[0] = (cp > 32'hFF) ? 32'hFD : cp;
						ult_pkg::WIDE_16: k = as_utf16(cp, u);
						default:          u[0] = invalid_scalar(cp) ? ult_pkg::REPL : cp;
					endcase
				end
				default: u[0] = {24'h0, cp[7:0]};
			endcase
			if (step_n + k > 4)
				return;
			for (int i = 0; i < k; i++) begin
				step_units[step_n] = u[i];
				step_eol[step_n]   = 1'b0;
				step_n++;
			end
		endfunction

		function void decode_utf8(logic [7:0] b);
			logic [31:0] cp;
			if (seq_len != 0) begin
				if (b[7:6] == 2'b10) begin
					partial = {partial[14:0], b[5:0]};
					seq_seen++;
					if (seq_seen >= seq_len) begin
						cp = {11'h0, partial};
						if ((seq_len == 3'd2 && cp < 32'h80) ||
								(seq_len == 3'd3 && cp < 32'h800) ||
								(seq_len == 3'd4 && cp < 32'h1_0000) || invalid_scalar(cp))
							cp = ult_pkg::REPL;
						clear_decoder();
						push_scalar(cp);
					end
					return;
				end
				// broken tail: replace, then take the byte as a new head
				clear_decoder();
				push_scalar(ult_pkg::REPL);
			end
			if (b[7] == 1'b0) begin
				push_scalar({24'h0, b});
			end else if (b[7:5] == 3'b110) begin
				partial  = {16'h0, b[4:0]};
				seq_len  = 3'd2;
				seq_seen = 3'd1;
			end else if (b[7:4] == 4'b1110) begin
				partial  = {17'h0, b[3:0]};
				seq_len  = 3'd3;
				seq_seen = 3'd1;
			end else if (b[7:3] == 5'b11110) begin
				partial  = {18'h0, b[2:0]};
				seq_len  = 3'd4;
				seq_seen = 3'd1;
			end else begin
				push_scalar(ult_pkg::REPL);
			end
		endfunction

		function void decode_utf16(logic [15:0] w);
			logic is_low;
			is_low = (w >= ult_pkg::LOW_SURR_LO && w <= ult_pkg::LOW_SURR_HI);
			if (high_held) begin
				if (is_low) begin
					push_scalar(32'h1_0000 + {12'h0, held_high, w[9:0]});
					clear_decoder();
					return;
				end
				clear_decoder();
				push_scalar(ult_pkg::REPL);
			end
			if (w >= ult_pkg::HIGH_SURR_LO && w <= ult_pkg::HIGH_SURR_HI) begin
				held_high = w[9:0];
				high_held = 1'b1;
			end else if (is_low) begin
				push_scalar(ult_pkg::REPL);
			end else begin
				push_scalar({16'h0, w});
			end
		endfunction

		function void set_reg(logic [1:0] idx, logic [5:0] val);
			case (idx)
				ult_pkg::REG_SOURCE_KIND: begin
					src_kind = val[2:0];
					clear_decoder();
				end
				ult_pkg::REG_TARGET_KIND: tgt_kind = val[2:0];
				ult_pkg::REG_WIDE_UNIT_BITS: begin
					wide_bits = val;
					clear_decoder();
				end
				default: ;
			endcase
		endfunction

		// note one accepted source word and queue the words it must produce
		function void take_unit(logic [31:0] raw);
			decode_mode_t mode;
			logic [31:0] u;
			out_word_t w;
			mode = source_mode();
			case (mode)
				DEC_UTF32: u = raw;
				DEC_UTF16: u = {16'h0, raw[15:0]};
				default:   u = {24'h0, raw[7:0]};
			endcase
			step_n = 0;
			if (u == 0) begin
				if (seq_len != 0 || high_held)
					push_scalar(ult_pkg::REPL);
				clear_decoder();
				step_units[step_n] = '0;
				step_eol[step_n]   = 1'b1;
				step_n++;
			end else begin
				case (mode)
					DEC_UTF8:  decode_utf8(u[7:0]);
					DEC_UTF16: decode_utf16(u[15:0]);
					default:   push_scalar(u);
				endcase
			end
			for (int i = 0; i < step_n; i++) begin
				w.unit = step_units[i];
				w.last = (i == step_n - 1);
				w.eol  = step_eol[i];
				expected_words.push_back(w);
			end
		endfunction

		function void check_word(logic [31:0] unit, logic last, logic eol);
			out_word_t w;
			if (expected_words.size() == 0) begin
				$error("unexpected word: out_unit=%h last_of_run=%b end_of_literal=%b",
					unit, last, eol);
				fails++;
				return;
			end
			w = expected_words.pop_front();
			if (unit !== w.unit) begin
				$error("out_unit: expected %h, got %h", w.unit, unit);
				fails++;
			end
			if (last !== w.last) begin
				$error("last_of_run: expected %b, got %b", w.last, last);
				fails++;
			end
			if (eol !== w.eol) begin
				$error("end_of_literal: expected %b, got %b", w.eol, eol);
				fails++;
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [1:0] cfg_index;
	logic [5:0] cfg_wdata;
	logic       in_calm;
	logic       out_calm;
	int         quiet_cycles = 0;

	ult_in_if  in_ch ();
	ult_out_if out_ch ();

	transcode_scoreboard sb;

	unicode_literal_transcoder u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Put random bits above the unit width on half the words; the block must
	// ignore them.
	function automatic logic [31:0] with_noise_above(logic [31:0] u, int bits);
		logic [31:0] n;
		n = $urandom();
		if (bits >= 32 || n[0])
			return u;
		return (n << bits) | u;
	endfunction

	// Offer one source word after a random gap and hold it until taken. Valid
	// stays high across back-to-back words.
	task automatic send_unit(logic [31:0] raw);
		int gap;
		gap = in_calm ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid   <= 1'b1;
		in_ch.in_unit <= raw;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		sb.take_unit(raw);
	endtask

	// Stop sending, wait for every owed word, then let the decoder settle: a
	// lead byte or high surrogate produces nothing yet may still be in flight.
	task automatic drain();
		in_ch.valid <= 1'b0;
		while (sb.expected_words.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Raise the write enable per write; the caller drops it after the last
	// write of a group so that back-to-back writes never toggle it.
	task automatic write_reg(logic [1:0] idx, logic [5:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		sb.set_reg(idx, val);
	endtask

	task automatic configure(logic [2:0] src, logic [2:0] tgt, logic [5:0] wide);
		drain();
		// kind registers keep only three bits; load junk above them
		write_reg(ult_pkg::REG_SOURCE_KIND, {3'($urandom_range(0, 7)), src});
		write_reg(ult_pkg::REG_TARGET_KIND, {3'($urandom_range(0, 7)), tgt});
		write_reg(ult_pkg::REG_WIDE_UNIT_BITS, wide);
		if ($urandom_range(0, 1))
			write_reg(REG_SPARE, 6'($urandom_range(0, 63)));
		cfg_we <= 1'b0;
	endtask

	// Sink side: stall for a random count before each word, or none while calm.
	initial begin
		int gap;
		out_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			gap = out_calm ? 0 : $urandom_range(0, 4);
			if (gap > 0) begin
				out_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (out_ch.valid !== 1'b1);
		end
	end

	// Check every word the block hands over.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
			sb.check_word(out_ch.out_unit, out_ch.last_of_run, out_ch.end_of_literal);
	end

	// Watchdog: give up when neither side has moved a word for too long.
	always @(posedge clk) begin
		if (arst_n !== 1'b1 || (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
				(out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		int          sent;
		int          pause_at;
		int          pick;
		int          n;
		int          bits;
		logic        paused;
		logic [31:0] cp;
		logic [31:0] enc [4];
		logic [31:0] burst [$];

		sb            = new();
		in_calm       = 1'b0;
		out_calm      = 1'b0;
		arst_n        <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_index     <= ult_pkg::REG_SOURCE_KIND;
		cfg_wdata     <= '0;
		in_ch.valid   <= 1'b0;
		in_ch.in_unit <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// UTF-8 into UTF-16: ASCII, a four-byte character that needs a
		// surrogate pair, an overlong pair, an encoded surrogate, a value past
		// U+10FFFF, a tail broken by ASCII, and a terminator cutting a sequence.
		configure(ult_pkg::KIND_UTF8, ult_pkg::KIND_UTF16, 6'd32);
		burst = '{32'h41, 32'hF0, 32'h9F, 32'h98, 32'h80, 32'hC0, 32'h80,
			32'hED, 32'hA0, 32'h80, 32'hF4, 32'h90, 32'h80, 32'h80,
			32'hC3, 32'h41, 32'hE2, 32'h82, 32'h0};
		foreach (burst[i]) send_unit(burst[i]);

		// UTF-8 to UTF-8: a tail broken by an invalid head owes two
		// replacements, only one fits; then a terminator hidden under junk bits.
		configure(ult_pkg::KIND_UTF8, ult_pkg::KIND_UTF8, 6'd32);
		burst = '{32'hE2, 32'hFF, 32'hFFFF_FF00};
		foreach (burst[i]) send_unit(burst[i]);

		// 16-bit wide source: a proper pair, then a high surrogate left alone.
		configure(ult_pkg::KIND_WIDE, ult_pkg::KIND_UTF32, 6'd16);
		burst = '{32'hD83D, 32'hDE00, 32'hD800, 32'hFFFF_0041};
		foreach (burst[i]) send_unit(burst[i]);

		// Random phases, each under its own register setting.
		for (int p = 0; p < PHASES; p++) begin
			configure(SRC_PLAN[p], TGT_PLAN[p], WIDE_PLAN[p]);
			in_calm  = ($urandom_range(0, 3) == 0);
			out_calm = ($urandom_range(0, 3) == 0);
			pause_at = $urandom_range(2, WORDS_PER_PHASE - 3);
			paused   = 1'b0;
			sent     = 0;
			while (sent < WORDS_PER_PHASE) begin
				// Hold off until the block owes nothing; sometimes retarget
				// there, which must leave an open sequence alone.
				if (!paused && sent >= pause_at) begin
					drain();
					if ($urandom_range(0, 1)) begin
						write_reg(ult_pkg::REG_TARGET_KIND, 6'($urandom_range(0, 63)));
						cfg_we <= 1'b0;
					end
					paused = 1'b1;
				end
				burst.delete();
				pick = $urandom_range(0, 99);
				case (sb.source_mode())
					DEC_UTF8: begin
						bits = 8;
						if (pick < 65) begin
							// well-formed character of random length
							case ($urandom_range(0, 3))
								0:       cp = $urandom_range(32'h1, 32'h7F);
								1:       cp = $urandom_range(32'h80, 32'h7FF);
								2:       cp = $urandom_range(32'h800, 32'hFFFF);
								default: cp = $urandom_range(32'h1_0000, 32'h10_FFFF);
							endcase
							n = sb.as_utf8(cp, enc);
							for (int i = 0; i < n; i++) burst.push_back(enc[i]);
						end else if (pick < 75) begin
							burst.push_back(32'h0);
						end else if (pick < 85) begin
							// cut a multibyte sequence short with any byte
							cp = $urandom_range(32'h80, 32'h10_FFFF);
							n  = sb.as_utf8(cp, enc);
							n  = $urandom_range(1, n - 1);
							for (int i = 0; i < n; i++) burst.push_back(enc[i]);
							burst.push_back($urandom_range(0, 255));
						end else if (pick < 93) begin
							// overlong, surrogate or beyond-range forms
							case ($urandom_range(0, 3))
								0: burst = '{32'hC0 | $urandom_range(0, 1),
									$urandom_range(32'h80, 32'hBF)};
								1: burst = '{32'hE0, $urandom_range(32'h80, 32'h9F),
									$urandom_range(32'h80, 32'hBF)};
								2: burst = '{32'hED, $urandom_range(32'hA0, 32'hBF),
									$urandom_range(32'h80, 32'hBF)};
								default: burst = '{32'hF4, $urandom_range(32'h90, 32'hBF),
									$urandom_range(32'h80, 32'hBF),
									$urandom_range(32'h80, 32'hBF)};
							endcase
						end else begin
							burst.push_back($urandom_range(0, 255));
						end
					end
					DEC_UTF16: begin
						bits = 16;
						if (pick < 45) begin
							burst.push_back($urandom_range(0, 1) ?
								$urandom_range(32'h1, 32'hD7FF) :
								$urandom_range(32'hE000, 32'hFFFF));
						end else if (pick < 70) begin
							cp = $urandom_range(32'h1_0000, 32'h10_FFFF) - 32'h1_0000;
							burst.push_back({16'h0, ult_pkg::HIGH_SURR_LO} + (cp >> 10));
							burst.push_back({16'h0, ult_pkg::LOW_SURR_LO} + (cp & 32'h3FF));
						end else if (pick < 80) begin
							// high surrogate followed by anything, zero included
							burst.push_back($urandom_range(ult_pkg::HIGH_SURR_LO,
								ult_pkg::HIGH_SURR_HI));
							burst.push_back($urandom_range(0, 32'hFFFF));
						end else if (pick < 86) begin
							burst.push_back($urandom_range(ult_pkg::LOW_SURR_LO,
								ult_pkg::LOW_SURR_HI));
						end else if (pick < 93) begin
							burst.push_back(32'h0);
						end else begin
							burst.push_back($urandom_range(0, 32'hFFFF));
						end
					end
					DEC_UTF32: begin
						bits = 32;
						if (pick < 40)
							burst.push_back($urandom_range(32'h1, ult_pkg::MAX_SCALAR));
						else if (pick < 52)
							burst.push_back($urandom_range(ult_pkg::SURR_LO, ult_pkg::SURR_HI));
						else if (pick < 68)
							burst.push_back($urandom());
						else if (pick < 80)
							case ($urandom_range(0, 3))
								0:       burst.push_back(ult_pkg::MAX_SCALAR);
								1:       burst.push_back(ult_pkg::MAX_SCALAR + 1);
								2:       burst.push_back(32'hFFFF_FFFF);
								default: burst.push_back(32'hFFFF);
							endcase
						else if (pick < 88)
							burst.push_back(32'h0);
						else
							burst.push_back($urandom_range(1, 255));
					end
					default: begin
						bits = 8;
						burst.push_back((pick < 88) ? $urandom_range(1, 255) : 0);
					end
				endcase
				foreach (burst[i]) send_unit(with_noise_above(burst[i], bits));
				sent += burst.size();
			end
		end

		// Let every owed word out, then allow for anything trailing.
		in_ch.valid <= 1'b0;
		while (sb.expected_words.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.fails == 0 && sb.expected_words.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
